@@ hdl/lob_pkg.sv @@
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants of the order book with best bid and offer.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int ORDER_SLOTS = 1024;
  localparam int LEVEL_SLOTS = 256;

  localparam int OIDX_W  = $clog2(ORDER_SLOTS);
  localparam int OCNT_W  = $clog2(ORDER_SLOTS + 1);
  localparam int KEY_W   = 64;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int TOT_W   = 42;
  localparam int TICK_W  = 16;
  localparam int TYPE_W  = 4;

  // update kinds
  typedef enum logic [TYPE_W-1:0] {
    REQ_ADD        = 4'd0,
    REQ_DELETE     = 4'd1,
    REQ_CANCEL     = 4'd2,
    REQ_EXECUTE    = 4'd3,
    REQ_REPLACE    = 4'd4,
    REQ_SNAP_START = 4'd5,
    REQ_SNAP_CLEAR = 4'd6,
    REQ_SNAP_END   = 4'd7,
    REQ_IGNORE     = 4'd8
  } req_t;

  // one resting order
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   rem;
  } ord_t;

  // one aggregated price level
  typedef struct packed {
    logic               v;
    logic [PRICE_W-1:0] price;
    logic [TOT_W-1:0]   total;
    logic [OCNT_W-1:0]  cnt;
  } lvl_t;

  // command to a level chain
  typedef struct packed {
    logic               add_en;
    logic               sub_en;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic               dec;
    logic               found;
    logic               rm;
  } lvl_cmd_t;

  // status of a level chain for the queried price
  typedef struct packed {
    logic found;
    logic one;
    logic full;
  } lvl_stat_t;

endpackage

@@ hdl/lob_ram.sv @@
// ----------------------------------------------------------------------------
// lob_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/lob_lvl_cell.sv @@
// ----------------------------------------------------------------------------
// lob_lvl_cell
// One price level of a sorted level chain; takes data from its neighbors.
// ----------------------------------------------------------------------------
module lob_lvl_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              is_ask,
  input  lob_pkg::lvl_cmd_t cmd,
  input  logic              prev_bt,
  input  lob_pkg::lvl_t     prev,
  input  lob_pkg::lvl_t     next,
  output lob_pkg::lvl_t     cur,
  output logic              bt,
  output logic              eq,
  output logic              one
);
  import lob_pkg::*;

  logic [TOT_W-1:0] q_ext;

  // compare against the queried price
  always_comb begin
    q_ext = {{(TOT_W-QTY_W){1'b0}}, cmd.qty};
    eq    = cur.v && (cur.price == cmd.price);
    bt    = cur.v && (is_ask ? (cur.price < cmd.price) : (cur.price > cmd.price));
    one   = eq && (cur.cnt == OCNT_W'(1));
  end

  // level update: merge, insert with shift down, reduce, or remove with shift up
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cur.v <= 1'b0;
    end else if (cmd.add_en) begin
      if (cmd.found) begin
        if (eq) begin
          cur.total <= cur.total + q_ext;
          cur.cnt   <= cur.cnt + OCNT_W'(1);
        end
      end else if (!bt) begin
        if (prev_bt) begin
          cur.v     <= 1'b1;
          cur.price <= cmd.price;
          cur.total <= q_ext;
          cur.cnt   <= OCNT_W'(1);
        end else begin
          cur <= prev;
        end
      end
    end else if (cmd.sub_en) begin
      if (cmd.rm) begin
        if (!bt) begin
          cur <= next;
        end
      end else if (eq) begin
        cur.total <= cur.total - q_ext;
        cur.cnt   <= cur.cnt - {{(OCNT_W-1){1'b0}}, cmd.dec};
      end
    end
  end

endmodule

@@ hdl/lob_lvl_chain.sv @@
// ----------------------------------------------------------------------------
// lob_lvl_chain
// Row of level cells kept sorted best first for one side of the book.
// ----------------------------------------------------------------------------
module lob_lvl_chain (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                is_ask,
  input  lob_pkg::lvl_cmd_t   cmd,
  output lob_pkg::lvl_stat_t  stat,
  output lob_pkg::lvl_t       best
);
  import lob_pkg::*;

  lvl_t                   cells [LEVEL_SLOTS];
  logic [LEVEL_SLOTS-1:0] bt_vec;
  logic [LEVEL_SLOTS-1:0] eq_vec;
  logic [LEVEL_SLOTS-1:0] one_vec;

  // cells with neighbor links
  for (genvar i = 0; i < LEVEL_SLOTS; i++) begin : g_cell
    logic prev_bt;
    lvl_t prev;
    lvl_t next;
    if (i == 0) begin : g_head
      assign prev_bt = 1'b1;
      assign prev    = '0;
    end else begin : g_mid
      assign prev_bt = bt_vec[i-1];
      assign prev    = cells[i-1];
    end
    if (i == LEVEL_SLOTS - 1) begin : g_tail
      assign next = '0;
    end else begin : g_body
      assign next = cells[i+1];
    end
    lob_lvl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .is_ask  (is_ask),
      .cmd     (cmd),
      .prev_bt (prev_bt),
      .prev    (prev),
      .next    (next),
      .cur     (cells[i]),
      .bt      (bt_vec[i]),
      .eq      (eq_vec[i]),
      .one     (one_vec[i])
    );
  end

  // status and best level
  always_comb begin
    stat.found = |eq_vec;
    stat.one   = |one_vec;
    stat.full  = cells[LEVEL_SLOTS-1].v;
    best       = cells[0];
  end

endmodule

@@ hdl/limit_order_book_bbo.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_bbo
// Order book for one instrument reporting best bid and ask after each update.
// ----------------------------------------------------------------------------
// An update is taken when start is high and busy is low. One result follows on
// the done strobe. It is valid for a single cycle, and the receiver cannot
// stall it. Orders sit packed in a RAM with one write and one read port and are
// looked up by a sweep over the resting orders, one read per cycle. After the
// sweep, an unknown reference, a duplicate add or an add to a full table goes
// straight to the result; an add checks and then updates its level chain; a
// delete, cancel or execute checks and then reduces or removes its level; a
// replace checks the new level, takes out the old order and then adds the new
// one. Snapshot controls, ignored updates and updates for another ticker skip
// the sweep. Price levels live in two sorted chains of cells, best level first.
// ticker_select is written through the cfg channel while the block is idle.
module limit_order_book_bbo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lob_pkg::TYPE_W-1:0]    req_type,
  input  logic [lob_pkg::TICK_W-1:0]    ticker,
  input  logic [lob_pkg::KEY_W-1:0]     ord_id,
  input  logic [lob_pkg::KEY_W-1:0]     new_ref,
  input  logic                          side,
  input  logic [lob_pkg::PRICE_W-1:0]   price,
  input  logic [lob_pkg::QTY_W-1:0]     qty,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lob_pkg::TICK_W-1:0]    cfg_data,
  output logic                          done,
  output logic                          bid_valid,
  output logic [lob_pkg::PRICE_W-1:0]   bid_px,
  output logic [lob_pkg::TOT_W-1:0]     bid_qty,
  output logic                          ask_valid,
  output logic [lob_pkg::PRICE_W-1:0]   ask_px,
  output logic [lob_pkg::TOT_W-1:0]     ask_qty,
  output logic                          applied,
  output logic                          table_full,
  output logic                          in_snapshot
);
  import lob_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_CHK_NEW, S_CHK_OLD,
    S_SUB_GO, S_ADD_CHK, S_ADD_GO, S_DONE
  } state_t;

  state_t              state;
  logic [TICK_W-1:0]   ticker_sel;
  logic                snap;
  logic [OCNT_W-1:0]   count;
  logic [TYPE_W-1:0]   r_type;
  logic [KEY_W-1:0]    r_ref;
  logic [KEY_W-1:0]    r_nref;
  logic                r_side;
  logic [PRICE_W-1:0]  r_price;
  logic [QTY_W-1:0]    r_qty;
  logic                r_applied;
  logic                r_full;
  logic [OCNT_W-1:0]   scan_addr;
  logic                rd_pend;
  logic [OCNT_W-1:0]   rd_idx;
  logic                hit;
  logic                hit_n;
  logic [OIDX_W-1:0]   hit_idx;
  ord_t                h;
  ord_t                last;
  logic [QTY_W-1:0]    sub_q;
  logic                sub_dec;
  logic                st_found;
  logic                st_full;
  logic                rm_flag;

  logic                match;
  logic                clear_book;
  logic                issuing;
  logic                q_side;
  lvl_cmd_t            cmd;
  lvl_cmd_t            bid_cmd;
  lvl_cmd_t            ask_cmd;
  lvl_stat_t           bid_stat;
  lvl_stat_t           ask_stat;
  lvl_stat_t           q_stat;
  lvl_t                bid_best;
  lvl_t                ask_best;
  logic                ram_we;
  logic [OIDX_W-1:0]   ram_waddr;
  ord_t                ram_wdata;
  ord_t                ram_rdata;
  logic                add_drop;

  // handshake and filter
  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign match     = (ticker == ticker_sel);
  assign issuing   = (scan_addr < count);

  // level chain commands and order RAM writes
  always_comb begin
    clear_book = (state == S_IDLE) && start &&
                 ((req_type == REQ_SNAP_START) ||
                  ((req_type == REQ_SNAP_CLEAR) && match));
    q_side     = ((state == S_CHK_OLD) || (state == S_SUB_GO)) ? h.side : r_side;
    add_drop   = (r_type == REQ_ADD) && !st_found && st_full;
    cmd.price  = ((state == S_CHK_OLD) || (state == S_SUB_GO)) ? h.price : r_price;
    cmd.add_en = (state == S_ADD_GO) && !add_drop;
    cmd.sub_en = (state == S_SUB_GO);
    cmd.qty    = (state == S_SUB_GO) ? sub_q : r_qty;
    cmd.dec    = sub_dec;
    cmd.found  = st_found;
    cmd.rm     = rm_flag;
    bid_cmd        = cmd;
    bid_cmd.add_en = cmd.add_en && !q_side;
    bid_cmd.sub_en = cmd.sub_en && !q_side;
    ask_cmd        = cmd;
    ask_cmd.add_en = cmd.add_en && q_side;
    ask_cmd.sub_en = cmd.sub_en && q_side;
    q_stat     = q_side ? ask_stat : bid_stat;

    ram_we    = 1'b0;
    ram_waddr = hit_idx;
    ram_wdata = last;
    if (state == S_ADD_GO && !add_drop) begin
      ram_we          = 1'b1;
      ram_waddr       = (r_type == REQ_ADD) ? count[OIDX_W-1:0] : hit_idx;
      ram_wdata.key   = (r_type == REQ_ADD) ? r_ref : r_nref;
      ram_wdata.side  = r_side;
      ram_wdata.price = r_price;
      ram_wdata.rem   = r_qty;
    end else if (state == S_SUB_GO && r_type != REQ_REPLACE) begin
      ram_we = 1'b1;
      if (!sub_dec) begin
        ram_wdata     = h;
        ram_wdata.rem = h.rem - r_qty;
      end
    end
  end

  lob_ram #(
    .WIDTH ($bits(ord_t)),
    .DEPTH (ORDER_SLOTS)
  ) u_orders (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr[OIDX_W-1:0]),
    .rdata (ram_rdata)
  );

  lob_lvl_chain u_bids (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear_book),
    .is_ask (1'b0),
    .cmd    (bid_cmd),
    .stat   (bid_stat),
    .best   (bid_best)
  );

  lob_lvl_chain u_asks (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear_book),
    .is_ask (1'b1),
    .cmd    (ask_cmd),
    .stat   (ask_stat),
    .best   (ask_best)
  );

  // sequencer, order count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ticker_sel <= '0;
      snap       <= 1'b0;
      count      <= '0;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        ticker_sel <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r_type    <= req_type;
            r_ref     <= ord_id;
            r_nref    <= new_ref;
            r_side    <= side;
            r_price   <= price;
            r_qty     <= qty;
            r_applied <= clear_book;
            r_full    <= 1'b0;
            scan_addr <= '0;
            rd_pend   <= 1'b0;
            hit       <= 1'b0;
            hit_n     <= 1'b0;
            if (clear_book) begin
              count <= '0;
              state <= S_DONE;
              if (req_type == REQ_SNAP_START) begin
                snap <= 1'b1;
              end
            end else if (req_type == REQ_SNAP_END) begin
              snap  <= 1'b0;
              state <= S_DONE;
            end else if (match && (req_type < REQ_SNAP_START)) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          // sweep resting orders, compare in the cycle after the read is issued
          if (issuing) begin
            scan_addr <= scan_addr + OCNT_W'(1);
          end
          rd_pend <= issuing;
          rd_idx  <= scan_addr;
          if (rd_pend) begin
            if (ram_rdata.key == r_ref) begin
              hit     <= 1'b1;
              hit_idx <= rd_idx[OIDX_W-1:0];
              h       <= ram_rdata;
            end
            if (ram_rdata.key == r_nref) begin
              hit_n <= 1'b1;
            end
            if ((rd_idx + OCNT_W'(1)) == count) begin
              last <= ram_rdata;
            end
          end
          if (!issuing && !rd_pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // a partial cut keeps the order, anything else takes all of it
          if (((r_type == REQ_CANCEL) || (r_type == REQ_EXECUTE)) && (r_qty < h.rem)) begin
            sub_q   <= r_qty;
            sub_dec <= 1'b0;
          end else begin
            sub_q   <= h.rem;
            sub_dec <= 1'b1;
          end
          unique case (r_type) inside
            REQ_ADD: begin
              if (hit) begin
                state <= S_DONE;
              end else if (count == OCNT_W'(ORDER_SLOTS)) begin
                r_full <= 1'b1;
                state  <= S_DONE;
              end else begin
                state <= S_ADD_CHK;
              end
            end
            REQ_DELETE, REQ_CANCEL, REQ_EXECUTE: begin
              state <= hit ? S_CHK_OLD : S_DONE;
            end
            REQ_REPLACE: begin
              state <= (hit && !hit_n) ? S_CHK_NEW : S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_CHK_NEW: begin
          st_found <= q_stat.found;
          st_full  <= q_stat.full;
          state    <= S_CHK_OLD;
        end
        S_CHK_OLD: begin
          // old level goes away when its last order leaves
          rm_flag <= q_stat.one && sub_dec;
          state   <= (r_type == REQ_REPLACE && !st_found && st_full &&
                      !(h.side == r_side && q_stat.one)) ? S_DONE : S_SUB_GO;
        end
        S_SUB_GO: begin
          if (r_type == REQ_REPLACE) begin
            state <= S_ADD_CHK;
          end else begin
            if (sub_dec) begin
              count <= count - OCNT_W'(1);
            end
            r_applied <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_ADD_CHK: begin
          st_found <= q_stat.found;
          st_full  <= q_stat.full;
          state    <= S_ADD_GO;
        end
        S_ADD_GO: begin
          if (add_drop) begin
            r_full <= 1'b1;
          end else begin
            if (r_type == REQ_ADD) begin
              count <= count + OCNT_W'(1);
            end
            r_applied <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          bid_valid   <= bid_best.v;
          bid_px      <= bid_best.v ? bid_best.price : '0;
          bid_qty     <= bid_best.v ? bid_best.total : '0;
          ask_valid   <= ask_best.v;
          ask_px      <= ask_best.v ? ask_best.price : '0;
          ask_qty     <= ask_best.v ? ask_best.total : '0;
          applied     <= r_applied;
          table_full  <= r_full;
          in_snapshot <= snap;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
